### design/lod4_pkg.sv
// Package for the 4x4 ordered-dither luma core.
// Holds request types, register indexes and the fixed luma, dither and quantizer constants.
// No dependencies.
package lod4_pkg;

    // Configuration port shape
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SINGLE_CHANNEL = 2'd2;

    // Rec.709 weights, 16 fraction bits (sum is 65536)
    localparam logic [15:0] WEIGHT_RED   = 16'd13933;
    localparam logic [15:0] WEIGHT_GREEN = 16'd46871;
    localparam logic [15:0] WEIGHT_BLUE  = 16'd4732;

    // x / 17 == (x * 241) >> 12 for every x up to 263
    localparam logic [7:0] RECIP_17       = 8'd241;
    localparam int         RECIP_17_SHIFT = 12;
    localparam logic [3:0] LEVEL_MAX      = 4'd15;
    localparam logic [3:0] ROUND_HALF     = 4'd8;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] luma;
        logic [3:0] level;
        logic [7:0] dithered;
        logic       frame_end;
    } t_pix_out;

    // Bayer entry minus 128, divided by 16 (exact, entries are multiples of 16).
    // Index is {row[1:0], col[1:0]}.
    function automatic logic signed [3:0] bayer_offset(input logic [3:0] pos);
        logic signed [3:0] off;
        case (pos)
            4'h0: off = -4'sd8;
            4'h1: off =  4'sd0;
            4'h2: off = -4'sd6;
            4'h3: off =  4'sd2;
            4'h4: off =  4'sd4;
            4'h5: off = -4'sd4;
            4'h6: off =  4'sd6;
            4'h7: off = -4'sd2;
            4'h8: off = -4'sd5;
            4'h9: off =  4'sd3;
            4'hA: off = -4'sd7;
            4'hB: off =  4'sd1;
            4'hC: off =  4'sd7;
            4'hD: off = -4'sd1;
            4'hE: off =  4'sd5;
            4'hF: off = -4'sd3;
            default: off = 4'sd0;
        endcase
        return off;
    endfunction

endpackage

### design/luma_ordered_dither_4x4_core.sv
// Top level of the 4x4 ordered-dither luma core: position counters, weight products,
// luma sum, Bayer bias, clamp and 16-level quantizer. Depends on lod4_pkg.
//
// Pipeline: input register (weight products, position), then result register (luma sum,
// Bayer bias, clamp and quantizer). Throughput: one pixel per cycle while the downstream
// side does not stall; the input register takes one more request while a finished result
// waits for the downstream side, then the input stalls.
// Reset (synchronous, active low): pipeline empty, counters at 0, frame size 1x1, color mode.
module luma_ordered_dither_4x4_core #(
    parameter int MAX_DIMENSION = 4096
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Pixel request channel
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  lod4_pkg::t_pix_in            i_in_req,
    // Result channel
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output lod4_pkg::t_pix_out           o_out_req,
    // Configuration write port
    input  logic                         i_cfg_we,
    input  logic [lod4_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [lod4_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import lod4_pkg::*;

    localparam int CW   = $clog2(MAX_DIMENSION);
    localparam int SW   = $clog2(MAX_DIMENSION + 1);
    localparam int CMPW = ((SW > CFG_DATA_W) ? SW : CFG_DATA_W) + 1;

    // Configuration registers
    logic [CFG_DATA_W-1:0] r_frame_width;
    logic [CFG_DATA_W-1:0] r_frame_height;
    logic                  r_single;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= CFG_DATA_W'(1);
            r_frame_height <= CFG_DATA_W'(1);
            r_single       <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FRAME_WIDTH:    r_frame_width  <= i_cfg_data;
                CFG_FRAME_HEIGHT:   r_frame_height <= i_cfg_data;
                CFG_SINGLE_CHANNEL: r_single       <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Effective frame size: zero acts as 1, oversize clamps to MAX_DIMENSION
    logic [CMPW-1:0] eff_w;
    logic [CMPW-1:0] eff_h;

    always_comb begin
        if (r_frame_width == '0) begin
            eff_w = CMPW'(1);
        end else if (CMPW'(r_frame_width) > CMPW'(MAX_DIMENSION)) begin
            eff_w = CMPW'(MAX_DIMENSION);
        end else begin
            eff_w = CMPW'(r_frame_width);
        end
        if (r_frame_height == '0) begin
            eff_h = CMPW'(1);
        end else if (CMPW'(r_frame_height) > CMPW'(MAX_DIMENSION)) begin
            eff_h = CMPW'(MAX_DIMENSION);
        end else begin
            eff_h = CMPW'(r_frame_height);
        end
    end

    // Pipeline handshake
    logic r_s1_valid;
    logic r_out_valid;
    logic out_load;
    logic in_accept;

    assign out_load   = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !out_load;
    assign in_accept  = i_in_valid && !o_in_stall;

    // Raster position counters
    logic [CW-1:0] r_col;
    logic [CW-1:0] r_row;
    logic          last_col;
    logic          last_row;

    assign last_col = (CMPW'(r_col) + CMPW'(1)) >= eff_w;
    assign last_row = (CMPW'(r_row) + CMPW'(1)) >= eff_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_accept) begin
            if (last_col) begin
                r_col <= '0;
                r_row <= last_row ? '0 : r_row + CW'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    // Stage 1: weight products and position capture
    logic [21:0] r_s1_prod_r;
    logic [23:0] r_s1_prod_g;
    logic [20:0] r_s1_prod_b;
    logic [7:0]  r_s1_gray;
    logic        r_s1_single;
    logic [3:0]  r_s1_pos;
    logic        r_s1_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (out_load) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_prod_r <= 22'(i_in_req.red * WEIGHT_RED);
            r_s1_prod_g <= 24'(i_in_req.green * WEIGHT_GREEN);
            r_s1_prod_b <= 21'(i_in_req.blue * WEIGHT_BLUE);
            r_s1_gray   <= i_in_req.red;
            r_s1_single <= r_single;
            r_s1_pos    <= {r_row[1:0], r_col[1:0]};
            r_s1_end    <= last_col && last_row;
        end
    end

    // Stage 2 logic: luma sum, Bayer bias, clamp, quantize
    logic [23:0]       luma_sum;
    logic [7:0]        luma;
    logic signed [9:0] biased;
    logic [7:0]        clamped;
    logic [8:0]        rounded;
    logic [16:0]       quot_prod;
    logic [4:0]        quot;
    logic [3:0]        level;

    always_comb begin
        luma_sum = 24'(r_s1_prod_r) + r_s1_prod_g + 24'(r_s1_prod_b);
        luma     = r_s1_single ? r_s1_gray : luma_sum[23:16];
        biased   = $signed({2'b00, luma}) + 10'(bayer_offset(r_s1_pos));
        if (biased < 0) begin
            clamped = 8'd0;
        end else if (biased > 10'sd255) begin
            clamped = 8'd255;
        end else begin
            clamped = biased[7:0];
        end
        rounded   = 9'(clamped) + 9'(ROUND_HALF);
        quot_prod = 17'(rounded) * 17'(RECIP_17);
        quot      = quot_prod[RECIP_17_SHIFT +: 5];
        level     = (quot > 5'(LEVEL_MAX)) ? LEVEL_MAX : quot[3:0];
    end

    // Result register
    t_pix_out r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.luma      <= luma;
            r_out.level     <= level;
            r_out.dithered  <= {level, level};
            r_out.frame_end <= r_s1_end;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

    // Checks
    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMPW'(r_col) < CMPW'(MAX_DIMENSION))
        else $error("column counter beyond maximum dimension");

    a_col_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && last_col |=> r_col == '0)
        else $error("column counter did not wrap at row end");

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_s1_valid && r_out_valid)
        else $error("input stalled with room in the pipeline");

    a_dither_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_req.dithered == {o_out_req.level, o_out_req.level})
        else $error("dithered value is not level times 17");

endmodule
